### hw/rtl/cfts_pkg.sv
`timescale 1ns / 1ps
// Package for the cycle fraction time sensor: widths, register indexes,
// function codes and reset values. No dependencies.
package cfts_pkg;

    // Field widths.
    localparam int TIME_BITS = 48;
    localparam int FRAC_BITS = 16;
    localparam int IV_BITS   = 32;
    localparam int FRAC_W    = FRAC_BITS + 1;

    // Stream payload widths, rounded up to whole bytes.
    localparam int S_TDATA_W = ((TIME_BITS + 1 + 7) / 8) * 8;
    localparam int M_PAY_W   = 1 + FRAC_W + 1 + TIME_BITS + 1 + TIME_BITS + 3;
    localparam int M_TDATA_W = ((M_PAY_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = TIME_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CYCLE_INTERVAL = 3'd0,
        REG_LOOP_MODE      = 3'd1,
        REG_START_TIME     = 3'd2,
        REG_STOP_TIME      = 3'd3
    } cfg_reg_t;

    // Input item kinds, carried in tuser.
    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_ENABLE = 1'b1;

    localparam logic [IV_BITS-1:0] IV_RESET = IV_BITS'(1000000);
    localparam logic [FRAC_W-1:0]  FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

    // Long division of {offset, FRAC_BITS zeros} by the interval, two bits a cycle.
    localparam int DIV_STEPS = (TIME_BITS + FRAC_BITS + 1) / 2;
    localparam int DIVD_W    = 2 * DIV_STEPS;
    localparam int CNT_W     = $clog2(DIV_STEPS);

endpackage

### hw/rtl/cycle_fraction_time_sensor.sv
`timescale 1ns / 1ps
// Top level of the cycle fraction time sensor: config registers, the sensor
// state machine and a radix-4 serial divider. Depends on cfts_pkg.
//
// Usage:
// - The input stream carries one item per transfer. tuser selects the kind:
//   a time tick (time_now used) or a write of the enabled flag
//   (enable_value used). Every item yields exactly one result transfer.
// - The result gives the cycle fraction in unsigned 1.16 fixed point
//   (65536 is 1.0), the cycle wrap time, the emitted time, and the active
//   flag with its rise and fall marks. Each value field reads 0 when its
//   valid flag is low.
// - An item is taken only once the previous one is done. The divider works
//   out the remainder and the fraction bits of (offset << 16) / cycle_interval
//   two bits a cycle, after setup steps for the wide compares, the offset and
//   the limit, and before a final step that settles the result.
// - A finished result sits in the output register; the block keeps
//   accepting and working on the next item. If the receiver still stalls
//   when that item is done, the block holds it until the output frees up.
// - Reset sets cycle_interval to 1000000, loop_mode, start and stop times to
//   0, the sensor enabled, inactive and not finished, with no fraction seen.
// - Configuration writes are taken at any edge with cfg_we high (loop mode and
//   start time only while inactive) and must only be issued while the block is idle.
module cycle_fraction_time_sensor (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: time_now [47:0], enable_value [48], zero padding above
    input  logic [cfts_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // tuser: func (0 time tick, 1 set enabled flag)
    input  logic                                s_axis_tuser,
    // Result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: fraction_valid [0], fraction [17:1], cycle_time_valid [18],
    // cycle_time [66:19], time_valid [67], time_out [115:68],
    // active_rise [116], active_fall [117], active [118], zero padding above
    output logic [cfts_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [cfts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cfts_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import cfts_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_CMP  = 6'b000010,
        ST_OFF  = 6'b000100,
        ST_LIM  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    // One radix-2 restoring step of the divider.
    function automatic logic [IV_BITS:0] div_step(
        input logic [IV_BITS-1:0] rem,
        input logic               bit_in,
        input logic [IV_BITS-1:0] divisor
    );
        logic [IV_BITS:0] trial;
        logic [IV_BITS:0] diff;
        trial = {rem, bit_in};
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor})
        begin
            div_step = {1'b1, diff[IV_BITS-1:0]};
        end
        else
        begin
            div_step = {1'b0, trial[IV_BITS-1:0]};
        end
    endfunction

    // Control state.
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   m_valid_reg;

    // Configuration registers.
    logic [IV_BITS-1:0]     iv_reg;
    logic                   loop_reg;
    logic [TIME_BITS-1:0]   start_reg;
    logic [TIME_BITS-1:0]   stop_reg;

    // Sensor state.
    logic                   enabled_reg, enabled_next;
    logic                   active_reg, active_next;
    logic                   finished_reg, finished_next;
    logic [FRAC_W-1:0]      last_frac_reg, last_frac_next;
    logic                   seen_reg, seen_next;
    logic [TIME_BITS-1:0]   last_time_reg, last_time_next;

    // Item datapath.
    logic                   func_reg;
    logic [TIME_BITS-1:0]   t_reg;
    logic                   en_reg;
    logic                   ge_start_reg;
    logic                   stop_ge_start_reg;
    logic                   t_ge_stop_reg;
    logic [TIME_BITS-1:0]   t1_reg;
    logic [TIME_BITS-1:0]   off_reg;
    logic                   over_reg;
    logic [TIME_BITS-1:0]   end_time_reg;
    logic [DIVD_W-1:0]      divd_reg;
    logic [IV_BITS-1:0]     rem_reg;
    logic [FRAC_BITS-1:0]   quo_reg;
    logic [M_TDATA_W-1:0]   m_data_reg;

    // Combinational helpers.
    logic [TIME_BITS-1:0]   src_time;
    logic                   stop_hit_off;
    logic [TIME_BITS-1:0]   t1_sel;
    logic [IV_BITS:0]       step_hi;
    logic [IV_BITS:0]       step_lo;
    logic                   in_fire;
    logic                   out_free;
    logic                   fin_fire;

    // Result of the item in the last cycle.
    logic                   stop_hit;
    logic                   go;
    logic                   one_shot_end;
    logic                   force_upd;
    logic                   fin_now;
    logic                   upd_f;
    logic [FRAC_W-1:0]      f_val;
    logic [TIME_BITS-1:0]   t1x;
    logic                   r_fv;
    logic [FRAC_W-1:0]      r_fr;
    logic                   r_cv;
    logic [TIME_BITS-1:0]   r_ct;
    logic                   r_tv;
    logic [TIME_BITS-1:0]   r_to;
    logic                   r_rise;
    logic                   r_fall;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign fin_fire      = (state_reg == ST_FIN) && out_free;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Offset source: the tick time, or the last time on an enabled-flag write.
    assign src_time     = (func_reg == FUNC_TICK) ? t_reg : last_time_reg;
    assign stop_hit_off = (func_reg == FUNC_TICK) && stop_ge_start_reg && t_ge_stop_reg;
    assign t1_sel       = stop_hit_off ? stop_reg : src_time;

    // Two chained divider steps per cycle.
    assign step_hi = div_step(rem_reg, divd_reg[DIVD_W-1], iv_reg);
    assign step_lo = div_step(step_hi[IV_BITS-1:0], divd_reg[DIVD_W-2], iv_reg);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:  state_next = ST_OFF;
            ST_OFF:  state_next = ST_LIM;
            ST_LIM:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sensor decisions once the fraction is known.
    always_comb
    begin
        stop_hit     = stop_ge_start_reg && t_ge_stop_reg;
        go           = 1'b0;
        one_shot_end = !loop_reg && over_reg;
        force_upd    = 1'b0;
        fin_now      = 1'b0;
        upd_f        = 1'b0;
        f_val        = {1'b0, quo_reg};
        t1x          = t1_reg;
        r_fv         = 1'b0;
        r_fr         = '0;
        r_cv         = 1'b0;
        r_ct         = '0;
        r_tv         = 1'b0;
        r_to         = '0;
        r_rise       = 1'b0;
        r_fall       = 1'b0;

        enabled_next   = enabled_reg;
        active_next    = active_reg;
        finished_next  = finished_reg;
        last_frac_next = last_frac_reg;
        seen_next      = seen_reg;
        last_time_next = last_time_reg;

        if (func_reg == FUNC_ENABLE)
        begin
            if (en_reg != enabled_reg)
            begin
                enabled_next = en_reg;
                if (!en_reg)
                begin
                    // Disabling: emit the fraction of the last time seen.
                    r_cv           = seen_reg && (f_val < last_frac_reg);
                    r_ct           = r_cv ? last_time_reg : '0;
                    r_fv           = 1'b1;
                    r_fr           = f_val;
                    last_frac_next = f_val;
                    seen_next      = 1'b1;
                    r_tv           = 1'b1;
                    r_to           = last_time_reg;
                    r_fall         = active_reg;
                    active_next    = 1'b0;
                end
                else
                begin
                    finished_next = 1'b0;
                end
            end
        end
        else if (!enabled_reg)
        begin
            last_time_next = t_reg;
        end
        else if (ge_start_reg)
        begin
            // A finished sensor stays silent at and past the stop time, and a
            // finished one-shot stays silent past its single cycle.
            go = !(stop_hit && finished_reg)
                 && !(one_shot_end && finished_reg && !stop_hit);
            if (go)
            begin
                r_rise    = !active_reg;
                force_upd = stop_hit || one_shot_end;
                fin_now   = stop_hit || one_shot_end || finished_reg;
                if (one_shot_end)
                begin
                    f_val = FRAC_ONE;
                    t1x   = end_time_reg;
                end
                upd_f = force_upd || !seen_reg || (f_val != last_frac_reg);
                r_cv  = one_shot_end || (upd_f && seen_reg && (f_val < last_frac_reg));
                r_ct  = r_cv ? t1x : '0;
                if (upd_f)
                begin
                    r_fv           = 1'b1;
                    r_fr           = f_val;
                    last_frac_next = f_val;
                    seen_next      = 1'b1;
                end
                if (force_upd || (t_reg != last_time_reg))
                begin
                    r_tv           = 1'b1;
                    r_to           = t_reg;
                    last_time_next = t_reg;
                end
                finished_next = fin_now;
                active_next   = !fin_now;
                r_fall        = fin_now;
            end
        end
    end

    // Control registers, configuration and sensor state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
            iv_reg        <= IV_RESET;
            loop_reg      <= 1'b0;
            start_reg     <= '0;
            stop_reg      <= '0;
            enabled_reg   <= 1'b1;
            active_reg    <= 1'b0;
            finished_reg  <= 1'b0;
            last_frac_reg <= '0;
            seen_reg      <= 1'b0;
            last_time_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_LIM)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == ST_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (fin_fire)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            if (fin_fire)
            begin
                enabled_reg   <= enabled_next;
                active_reg    <= active_next;
                finished_reg  <= finished_next;
                last_frac_reg <= last_frac_next;
                seen_reg      <= seen_next;
                last_time_reg <= last_time_next;
            end

            // Configuration writes; loop mode and start hold while active.
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CYCLE_INTERVAL:
                    begin
                        iv_reg       <= (cfg_data[IV_BITS-1:0] == '0) ? IV_BITS'(1)
                                                                       : cfg_data[IV_BITS-1:0];
                        finished_reg <= 1'b0;
                    end
                    REG_LOOP_MODE:
                    begin
                        if (!active_reg)
                        begin
                            loop_reg     <= cfg_data[0];
                            finished_reg <= 1'b0;
                        end
                    end
                    REG_START_TIME:
                    begin
                        if (!active_reg)
                        begin
                            start_reg    <= cfg_data[TIME_BITS-1:0];
                            finished_reg <= 1'b0;
                        end
                    end
                    REG_STOP_TIME:
                    begin
                        stop_reg     <= cfg_data[TIME_BITS-1:0];
                        finished_reg <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Item datapath: wide compares, offset, divider and output register.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg <= s_axis_tuser;
            t_reg    <= s_axis_tdata[TIME_BITS-1:0];
            en_reg   <= s_axis_tdata[TIME_BITS];
        end

        if (state_reg == ST_CMP)
        begin
            ge_start_reg      <= src_time >= start_reg;
            stop_ge_start_reg <= stop_reg >= start_reg;
            t_ge_stop_reg     <= t_reg >= stop_reg;
        end

        if (state_reg == ST_OFF)
        begin
            t1_reg  <= t1_sel;
            off_reg <= ge_start_reg ? (t1_sel - start_reg) : '0;
        end

        if (state_reg == ST_LIM)
        begin
            over_reg     <= off_reg >= TIME_BITS'(iv_reg);
            end_time_reg <= start_reg + TIME_BITS'(iv_reg);
            divd_reg     <= DIVD_W'({off_reg, {FRAC_BITS{1'b0}}});
            rem_reg      <= '0;
            quo_reg      <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            divd_reg <= {divd_reg[DIVD_W-3:0], 2'b00};
            rem_reg  <= step_lo[IV_BITS-1:0];
            quo_reg  <= {quo_reg[FRAC_BITS-3:0], step_hi[IV_BITS], step_lo[IV_BITS]};
        end

        if (fin_fire)
        begin
            m_data_reg <= M_TDATA_W'({active_next, r_fall, r_rise, r_to, r_tv,
                                      r_ct, r_cv, r_fr, r_fv});
        end
    end

    // The partial remainder always stays below the interval.
    a_rem_below_iv: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < iv_reg))
        else $error("divider remainder reached the interval");

    // The divider runs its full count and then settles the result.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == CNT_W'(DIV_STEPS - 1)) |=> (state_reg == ST_FIN))
        else $error("divider did not hand over to the result cycle");

    // A sensor that fell inactive cannot report itself active.
    a_fall_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_data_reg[M_PAY_W-2]) |-> !m_data_reg[M_PAY_W-1])
        else $error("active flag set together with a fall");

    // A fraction never exceeds one, and reads zero when not emitted.
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> ((m_data_reg[FRAC_W:1] <= FRAC_ONE)
                         && (m_data_reg[0] || m_data_reg[FRAC_W:1] == '0)))
        else $error("fraction out of range");

    // A loaded result is presented, and the block is back in idle.
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        fin_fire |=> m_valid_reg && (state_reg == ST_IDLE))
        else $error("settled result was not presented");

endmodule
